[design/assert_macros.svh]
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge, reset included.
`define SWRP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while reset is released.
`define SWRP_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[design/swrp_pkg.sv]
// Package: widths, types and helpers of the sliding window rate pacer.
`default_nettype none

package swrp_pkg;

    localparam int WINDOW_DEPTH = 100;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);

    localparam int BYTE_W   = 24;
    localparam int TIME_W   = 48;
    localparam int PACE_W   = 24;
    localparam int DELAY_W  = 31;
    localparam int PROD_W   = 48;
    localparam int ALLOW_W  = 57;

    localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        logic [TIME_W-1:0] rec_time;
        logic [TIME_W-1:0] rec_total;
    } t_record;

    // Input register contents handed to the window store.
    typedef struct packed {
        logic              valid;
        logic              on;
        logic [BYTE_W-1:0] count;
        logic [TIME_W-1:0] now;
    } t_stage_a;

    // Window store output: the new record and the oldest record.
    typedef struct packed {
        logic              valid;
        logic              on;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] total;
        logic [TIME_W-1:0] old_time;
        logic [TIME_W-1:0] old_total;
    } t_win_out;

    function automatic t_slot next_slot(input t_slot s);
        return (s == t_slot'(WINDOW_DEPTH - 1)) ? '0 : t_slot'(s + 1'b1);
    endfunction

endpackage

`default_nettype wire

[design/swrp_window.sv]
// Window store: circular record memory, slot pointers and running byte total.
`default_nettype none

module swrp_window (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire swrp_pkg::t_stage_a i_a,
    output swrp_pkg::t_win_out      o_b
);

    swrp_pkg::t_record mem [swrp_pkg::WINDOW_DEPTH];

    logic [swrp_pkg::TIME_W-1:0]  r_total, n_total;
    swrp_pkg::t_slot              r_newest, n_newest;
    swrp_pkg::t_slot              r_oldest, n_oldest;
    logic [swrp_pkg::COUNT_W-1:0] r_count, n_count;
    logic                         r_zero_valid;

    logic                         upd;
    logic                         full;
    swrp_pkg::t_slot              rd_addr;

    swrp_pkg::t_record            r_old_rec;
    logic                         r_old_zero;
    logic                         r_b_valid;
    logic                         r_b_on;
    logic [swrp_pkg::TIME_W-1:0]  r_b_now;
    logic [swrp_pkg::TIME_W-1:0]  r_b_total;

    always_comb begin
        upd      = i_a.valid && i_a.on;
        full     = r_count >= swrp_pkg::COUNT_W'(swrp_pkg::WINDOW_DEPTH);
        n_total  = r_total + swrp_pkg::TIME_W'(i_a.count);
        n_newest = swrp_pkg::next_slot(r_newest);
        n_oldest = full ? swrp_pkg::next_slot(r_oldest) : r_oldest;
        n_count  = full ? r_count : swrp_pkg::COUNT_W'(r_count + 1'b1);
        // The new record never lands on the slot that is read as oldest.
        rd_addr  = upd ? n_oldest : r_oldest;
    end

    always_ff @(posedge i_clk) begin
        if (upd) begin
            mem[n_newest] <= '{rec_time: i_a.now, rec_total: n_total};
        end
        r_old_rec <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total      <= '0;
            r_newest     <= '0;
            r_oldest     <= '0;
            r_count      <= swrp_pkg::COUNT_W'(1);
            r_zero_valid <= 1'b0;
            r_old_zero   <= 1'b0;
            r_b_valid    <= 1'b0;
        end else begin
            r_b_valid  <= i_a.valid;
            // Slot zero reads as cleared until its first write.
            r_old_zero <= (rd_addr == '0) && !r_zero_valid;
            if (upd) begin
                r_total  <= n_total;
                r_newest <= n_newest;
                r_oldest <= n_oldest;
                r_count  <= n_count;
                if (n_newest == '0) begin
                    r_zero_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_on    <= i_a.on;
        r_b_now   <= i_a.now;
        r_b_total <= n_total;
    end

    always_comb begin
        o_b.valid     = r_b_valid;
        o_b.on        = r_b_on;
        o_b.now       = r_b_now;
        o_b.total     = r_b_total;
        o_b.old_time  = r_old_zero ? '0 : r_old_rec.rec_time;
        o_b.old_total = r_old_zero ? '0 : r_old_rec.rec_total;
    end

endmodule

`default_nettype wire

[design/swrp_out_fifo.sv]
// Result queue: small FIFO of delay words between the pipeline and the output.
`default_nettype none

module swrp_out_fifo (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [swrp_pkg::DELAY_W-1:0] i_data,
    input  wire logic                         i_pop,
    output logic                              o_valid,
    output logic [swrp_pkg::DELAY_W-1:0]      o_data
);

    logic [swrp_pkg::DELAY_W-1:0]    r_mem [swrp_pkg::FIFO_DEPTH];
    logic [swrp_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [swrp_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [swrp_pkg::CREDIT_W-1:0]   r_fill;
    logic                            pop_ok;

    assign pop_ok  = i_pop && (r_fill != '0);
    assign o_valid = r_fill != '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // No overflow guard: the top level only admits words it has room for.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, pop_ok})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/sliding_window_rate_pacer.sv]
// Top level: sliding window receive pacer with a six-stage pipeline and a result queue.
//
// Input channel (i_in_valid / o_in_ready) takes one word per receive event:
// i_byte_count and i_now_us. Output channel (o_out_valid / i_out_ready)
// returns exactly one o_delay_us word per input word, in order.
// i_cfg_we writes i_cfg_pace_q16 (us per byte, Q16); zero turns pacing off,
// and then nothing is recorded and every delay is zero.
// Throughput: one word per cycle, sustained, while the receiver keeps up.
// Stages: input register, record memory write plus oldest-record read,
// byte/time differences, two 24x24 partial products, allowance sum, then
// compare/saturate into the queue. The record memory has one write and one
// read port; each word reads the oldest record and, with pacing on, writes one.
// Stalls: the pipeline never stops. A credit counter tracks words accepted
// but not yet delivered; o_in_ready drops once the 8-entry result queue
// could be filled, so an output stall backs up into the input only after
// eight words are pending.
// Reset (i_rst_n low, synchronous): pace goes to zero, the window holds a
// single cleared record, the queue and pipeline are emptied. No clearing
// pass is needed; slot zero is tracked with one valid flag.
`default_nettype none

module sliding_window_rate_pacer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [swrp_pkg::PACE_W-1:0]  i_cfg_pace_q16,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [swrp_pkg::BYTE_W-1:0]  i_byte_count,
    input  wire logic [swrp_pkg::TIME_W-1:0]  i_now_us,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [swrp_pkg::DELAY_W-1:0]      o_delay_us
);

    // Config register
    logic [swrp_pkg::PACE_W-1:0] r_pace;

    // Credits: words accepted and not yet taken by the receiver
    logic [swrp_pkg::CREDIT_W-1:0] r_credit;
    logic                          in_acc;
    logic                          out_acc;

    // Stage A: input register
    logic                        r_a_valid;
    logic                        r_a_on;
    logic [swrp_pkg::BYTE_W-1:0] r_a_count;
    logic [swrp_pkg::TIME_W-1:0] r_a_now;
    swrp_pkg::t_stage_a          stage_a;

    // Stage B: window store output
    swrp_pkg::t_win_out          stage_b;

    // Stage C: bytes and elapsed time across the window
    logic                        r_c_valid;
    logic                        r_c_on;
    logic [swrp_pkg::TIME_W-1:0] r_c_bytes;
    logic [swrp_pkg::TIME_W-1:0] r_c_elapsed;

    // Stage D: partial products
    logic                        r_d_valid;
    logic                        r_d_on;
    logic [swrp_pkg::PROD_W-1:0] r_d_hi;
    logic [swrp_pkg::PROD_W-1:0] r_d_lo;
    logic [swrp_pkg::TIME_W-1:0] r_d_elapsed;

    // Stage E: allowed time
    logic                         r_e_valid;
    logic                         r_e_on;
    logic [swrp_pkg::ALLOW_W-1:0] r_e_allowed;
    logic [swrp_pkg::TIME_W-1:0]  r_e_elapsed;

    // Stage F: delay into the queue
    logic [swrp_pkg::ALLOW_W:0]    diff;
    logic [swrp_pkg::DELAY_W-1:0]  n_delay;

    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = o_out_valid && i_out_ready;
    assign o_in_ready = r_credit < swrp_pkg::CREDIT_W'(swrp_pkg::FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pace   <= '0;
            r_credit <= '0;
        end else begin
            if (i_cfg_we) begin
                r_pace <= i_cfg_pace_q16;
            end
            case ({in_acc, out_acc})
                2'b10:   r_credit <= r_credit + 1'b1;
                2'b01:   r_credit <= r_credit - 1'b1;
                default: r_credit <= r_credit;
            endcase
        end
    end

    // Valid bits of the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            r_a_valid <= in_acc;
            r_c_valid <= stage_b.valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    // Payload of the pipeline
    always_ff @(posedge i_clk) begin
        r_a_on    <= r_pace != '0;
        r_a_count <= i_byte_count;
        r_a_now   <= i_now_us;

        // Differences wrap modulo 2^48
        r_c_on      <= stage_b.on;
        r_c_bytes   <= stage_b.total - stage_b.old_total;
        r_c_elapsed <= stage_b.now - stage_b.old_time;

        // bytes * pace split at bit 24 of bytes
        r_d_on      <= r_c_on;
        r_d_hi      <= {{swrp_pkg::PACE_W{1'b0}}, r_c_bytes[swrp_pkg::TIME_W-1:24]}
                       * {{24{1'b0}}, r_pace};
        r_d_lo      <= {{swrp_pkg::PACE_W{1'b0}}, r_c_bytes[23:0]}
                       * {{24{1'b0}}, r_pace};
        r_d_elapsed <= r_c_elapsed;

        // floor(bytes * pace / 2^16) = (hi << 8) + (lo >> 16)
        r_e_on      <= r_d_on;
        r_e_allowed <= {1'b0, r_d_hi, 8'b0}
                       + {25'b0, r_d_lo[swrp_pkg::PROD_W-1:16]};
        r_e_elapsed <= r_d_elapsed;
    end

    assign stage_a = '{valid: r_a_valid, on: r_a_on, count: r_a_count, now: r_a_now};

    swrp_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (stage_a),
        .o_b     (stage_b)
    );

    // Delay is allowed minus elapsed when positive, saturated to 31 bits
    always_comb begin
        diff = {1'b0, r_e_allowed} - {10'b0, r_e_elapsed};
        if (!r_e_on || diff[swrp_pkg::ALLOW_W] || (diff == '0)) begin
            n_delay = '0;
        end else if (diff[swrp_pkg::ALLOW_W-1:swrp_pkg::DELAY_W] != '0) begin
            n_delay = swrp_pkg::DELAY_MAX;
        end else begin
            n_delay = diff[swrp_pkg::DELAY_W-1:0];
        end
    end

    swrp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_e_valid),
        .i_data  (n_delay),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (o_delay_us)
    );

endmodule

`default_nettype wire

[design/swrp_checker.sv]
// Port checker for the sliding window rate pacer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module swrp_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_cfg_we,
    input wire logic [swrp_pkg::PACE_W-1:0]  i_cfg_pace_q16,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_ready,
    input wire logic [swrp_pkg::BYTE_W-1:0]  i_byte_count,
    input wire logic [swrp_pkg::TIME_W-1:0]  i_now_us,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [swrp_pkg::DELAY_W-1:0] o_delay_us
);

    `SWRP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!o_out_valid && o_in_ready), "reset must empty the block and open the input")

    `SWRP_ASSERT_RUN(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_delay_us)), "stalled output word changed or vanished")

    `SWRP_ASSERT_RUN(a_ready_fall, i_clk, i_rst_n, $fell(o_in_ready) |-> $past(i_in_valid && o_in_ready), "input ready dropped without an accepted word")

    `SWRP_ASSERT_RUN(a_valid_fall, i_clk, i_rst_n, $fell(o_out_valid) |-> $past(i_out_ready), "output word dropped without being taken")

endmodule

bind sliding_window_rate_pacer swrp_checker u_swrp_checker (.*);

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench of the sliding window rate pacer: directed and random words.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = swrp_pkg::WINDOW_DEPTH;
    localparam int LATENCY        = 5;     // input register to result queue; drain_results waits past it
    localparam int LONG_STALL     = 200;   // receiver hold-off, well past the 8-word queue
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake
    localparam int PEND_SLOTS     = 64;    // prediction ring, far above the words in flight

    typedef logic [swrp_pkg::BYTE_W-1:0]  t_bytes;
    typedef logic [swrp_pkg::TIME_W-1:0]  t_usec;
    typedef logic [swrp_pkg::PACE_W-1:0]  t_pace;
    typedef logic [swrp_pkg::DELAY_W-1:0] t_delay;

    localparam t_pace PACE_OFF = '0;
    localparam t_pace PACE_MIN = 24'd1;
    localparam t_pace PACE_MAX = '1;
    localparam t_pace PACE_5MB = 24'd13107;   // 0.2 us per byte

    // DUT-facing signals; every input starts at a known value
    logic   clk        = 1'b0;
    logic   rst_n      = 1'b0;
    logic   cfg_we     = 1'b0;
    t_pace  cfg_pace   = '0;
    logic   in_valid   = 1'b0;
    t_bytes byte_count = '0;
    t_usec  now_us     = '0;
    logic   out_ready  = 1'b0;
    wire    in_ready;
    wire    out_valid;
    t_delay delay_us;

    // Idle rates (percent of cycles) and the long receiver hold-off request
    int unsigned send_idle_pct = 17;
    int unsigned recv_idle_pct = 84;
    int          stall_seq     = 0;
    int          stall_seen    = 0;
    int          hold_left     = 0;

    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    t_delay      pending_delays[PEND_SLOTS];   // predicted delay per accepted word
    int unsigned pend_head = 0;                // oldest prediction not yet checked
    int unsigned pend_tail = 0;                // next free prediction slot

    // Predicted window: circular record store, same layout as the block
    t_usec       win_time [DEPTH];
    t_usec       win_total[DEPTH];
    int unsigned win_oldest;
    int unsigned win_newest;
    int unsigned win_fill;
    t_pace       pace_model;
    t_usec       traffic_clock;   // timestamp base of well-formed traffic

    sliding_window_rate_pacer i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_pace_q16 (cfg_pace),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_byte_count   (byte_count),
        .i_now_us       (now_us),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_delay_us     (delay_us)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: random idling, plus a long hold-off whenever a test bumps stall_seq.
    // While held off the result queue fills and the block has to drop in_ready.
    always @(posedge clk) begin
        if (stall_seen != stall_seq) begin
            stall_seen <= stall_seq;
            hold_left  <= LONG_STALL;
            out_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input t_delay got, input t_delay want);
        mismatch_count++;
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Result checker: every delivered word is matched against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pend_head == pend_tail)
                report_mismatch("delay word with nothing pending", delay_us, '0);
            else begin
                if (delay_us !== pending_delays[pend_head % PEND_SLOTS])
                    report_mismatch("delay_us", delay_us,
                                    pending_delays[pend_head % PEND_SLOTS]);
                pend_head++;
            end
        end
    end

    // Watchdog: a run of cycles with no handshake on either side means a hang
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Predicts the delay for one accepted word and advances the window.
    // With pacing off nothing is recorded. A full window recycles the oldest slot.
    function automatic t_delay pace_delay(input t_bytes cnt, input t_usec stamp);
        t_usec       total;
        t_usec       bytes;
        t_usec       elapsed;
        logic [71:0] product;
        logic [56:0] allowed;
        if (pace_model == PACE_OFF)
            return '0;
        total      = win_total[win_newest] + cnt;   // wraps modulo 2^48
        win_newest = (win_newest + 1) % DEPTH;
        if (win_fill >= DEPTH)
            win_oldest = (win_oldest + 1) % DEPTH;
        else
            win_fill++;
        win_time[win_newest]  = stamp;
        win_total[win_newest] = total;
        bytes   = total - win_total[win_oldest];
        elapsed = stamp - win_time[win_oldest];    // backwards time looks huge
        product = 72'(bytes) * 72'(pace_model);
        allowed = 57'(product >> 16);
        if (allowed <= 57'(elapsed))
            return '0;
        if (allowed - 57'(elapsed) > 57'(swrp_pkg::DELAY_MAX))
            return swrp_pkg::DELAY_MAX;
        return t_delay'(allowed - 57'(elapsed));
    endfunction

    // Offers one word; valid stays up through back-to-back words (no lower/raise in one step)
    task automatic send_word(input t_bytes cnt, input t_usec stamp);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        byte_count <= cnt;
        now_us     <= stamp;
        do @(posedge clk); while (!in_ready);
        pending_delays[pend_tail % PEND_SLOTS] = pace_delay(cnt, stamp);
        pend_tail++;
    endtask

    // Sender pauses until every delay has come back, then lets the pipe settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pend_head != pend_tail)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic set_pace(input t_pace value);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_pace <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        pace_model = value;
    endtask

    // Mostly well-formed receive traffic: rising timestamps spaced near the
    // configured pace (half, equal, double, or arbitrary), so delays land both
    // above and at zero. The rest is noise: time stepping back, or wild words.
    task automatic run_traffic(input int n_words);
        t_bytes cnt;
        t_usec  stamp;
        t_usec  fair;
        int     shape;
        repeat (n_words) begin
            case ($urandom_range(7))
                0: cnt = '0;
                1: cnt = '1;
                2, 3: cnt = t_bytes'($urandom_range(63));
                4, 5: cnt = t_bytes'($urandom_range(64, 1500));
                6: cnt = t_bytes'($urandom_range(65535));
                default: cnt = t_bytes'($urandom());
            endcase
            fair = t_usec'((48'(cnt) * 48'(pace_model)) >> 16);
            case ($urandom_range(3))
                0: traffic_clock += fair >> 1;
                1: traffic_clock += fair;
                2: traffic_clock += fair << 1;
                default: traffic_clock += t_usec'($urandom_range(2000));
            endcase
            shape = $urandom_range(99);
            if (shape < 85)
                stamp = traffic_clock;
            else if (shape < 93)
                stamp = traffic_clock - t_usec'($urandom_range(1, 100000));
            else
                stamp = t_usec'({$urandom(), $urandom()});
            send_word(cnt, stamp);
        end
    endtask

    // Reset value of the pace is zero: every delay must be zero, nothing recorded
    task automatic test_pacing_off();
        send_word('0, '0);
        send_word('1, '1);
        send_word(t_bytes'($urandom()), t_usec'({$urandom(), $urandom()}));
    endtask

    // Field and register extremes: saturation, huge elapsed time, smallest pace
    task automatic test_field_extremes();
        set_pace(PACE_MAX);
        send_word('1, '0);                        // allowance far past 2^31-1
        send_word('0, '1);                        // elapsed near 2^48, no delay
        send_word(24'd1, 48'd1);
        send_word('1, '1);
        set_pace(PACE_MIN);
        send_word('1, '0);
        send_word('0, 48'h8000_0000_0000);
        send_word(24'd1, '0);
        set_pace(PACE_5MB);
        send_word(24'd1500, 48'd100);
        send_word(24'd1500, 48'd400);
        send_word('0, 48'd400);
        send_word(24'h80_0000, 48'd401);
        send_word(24'h7F_FFFF, 48'h7FFF_FFFF_FFFF);
    endtask

    // Slow receiver: window fills and wraps around at a typical pace
    task automatic test_paced_traffic();
        send_idle_pct = 17;
        recv_idle_pct = 84;
        set_pace(PACE_5MB);
        traffic_clock = t_usec'({$urandom(), $urandom()});
        run_traffic(170);
    endtask

    // Long receiver hold-off while words keep coming, then a full drain
    task automatic test_backpressure();
        drain_results();
        stall_seq <= stall_seq + 1;
        run_traffic(40);
        drain_results();
    endtask

    // Slow sender, random pace
    task automatic test_slow_sender();
        send_idle_pct = 84;
        recv_idle_pct = 17;
        set_pace(t_pace'($urandom_range(1, 24'hFF_FFFF)));
        run_traffic(150);
    endtask

    // Full rate, sweeping the pace through its extremes and off again;
    // timestamps start just below the 2^48 wrap
    task automatic test_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        traffic_clock = 48'hFFFF_FFF0_0000;
        set_pace(PACE_MIN);
        run_traffic(60);
        set_pace(PACE_OFF);
        run_traffic(20);
        set_pace(PACE_MAX);
        run_traffic(60);
    endtask

    initial begin
        for (int s = 0; s < DEPTH; s++) begin
            win_time[s]  = '0;
            win_total[s] = '0;
        end
        win_oldest    = 0;
        win_newest    = 0;
        win_fill      = 1;
        pace_model    = PACE_OFF;
        traffic_clock = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_pacing_off();
        test_field_extremes();
        test_paced_traffic();
        test_backpressure();
        test_slow_sender();
        test_full_rate();

        drain_results();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
